### sv/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared widths, register indexes, reset values and stage types of the
// clamped PID speed controller.
// ----------------------------------------------------------------------------
package cpsc_pkg;

  // Fraction bits of the Q8.8 gains
  localparam int FRAC_BITS = 8;

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 16;
  localparam int DIFF_W     = 17;
  localparam int INTEG_W    = 24;
  localparam int DERIV_W    = 17;
  localparam int LIM15_W    = 15;
  localparam int ILIM_W     = 23;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Product and sum widths
  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PI_W  = GAIN_W + INTEG_W;
  localparam int PD_W  = GAIN_W + DERIV_W;
  localparam int SUM_W = PI_W + 2;

  // Bias that turns an arithmetic shift into truncation toward zero
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_GAIN_P         = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I         = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D         = 16'd0;
  localparam logic [LIM15_W-1:0] RST_ERROR_LIMIT    = 15'd5000;
  localparam logic [LIM15_W-1:0] RST_DEADBAND       = 15'd0;
  localparam logic [ILIM_W-1:0]  RST_INTEGRAL_LIMIT = 23'd5000;
  localparam logic [LIM15_W-1:0] RST_DRIVE_LIMIT    = 15'd5000;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM15_W-1:0]       error_limit;
    logic [LIM15_W-1:0]       deadband;
    logic [ILIM_W-1:0]        integral_limit;
    logic [LIM15_W-1:0]       drive_limit;
  } cfg_t;

  // Error, integral and derivative of one item
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } terms_t;

  // Weighted terms of one item
  typedef struct packed {
    logic signed [PP_W-1:0] pp;
    logic signed [PI_W-1:0] pi;
    logic signed [PD_W-1:0] pd;
  } prod_t;

endpackage

### sv/cpsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpsc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cpsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cpsc_pkg::cfg_t                   cfg
);

  // Always take writes
  assign cfg_ready = 1'b1;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= cpsc_pkg::RST_GAIN_P;
      cfg.gain_i         <= cpsc_pkg::RST_GAIN_I;
      cfg.gain_d         <= cpsc_pkg::RST_GAIN_D;
      cfg.error_limit    <= cpsc_pkg::RST_ERROR_LIMIT;
      cfg.deadband       <= cpsc_pkg::RST_DEADBAND;
      cfg.integral_limit <= cpsc_pkg::RST_INTEGRAL_LIMIT;
      cfg.drive_limit    <= cpsc_pkg::RST_DRIVE_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpsc_pkg::REG_GAIN_P:         cfg.gain_p <= cfg_data[cpsc_pkg::GAIN_W-1:0];
        cpsc_pkg::REG_GAIN_I:         cfg.gain_i <= cfg_data[cpsc_pkg::GAIN_W-1:0];
        cpsc_pkg::REG_GAIN_D:         cfg.gain_d <= cfg_data[cpsc_pkg::GAIN_W-1:0];
        cpsc_pkg::REG_ERROR_LIMIT:    cfg.error_limit <= cfg_data[cpsc_pkg::LIM15_W-1:0];
        cpsc_pkg::REG_DEADBAND:       cfg.deadband <= cfg_data[cpsc_pkg::LIM15_W-1:0];
        cpsc_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[cpsc_pkg::ILIM_W-1:0];
        cpsc_pkg::REG_DRIVE_LIMIT:    cfg.drive_limit <= cfg_data[cpsc_pkg::LIM15_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/cpsc_error_stage.sv
// ----------------------------------------------------------------------------
// cpsc_error_stage
// Input register, then error clamp, deadband, integral and derivative with
// the controller state.
// ----------------------------------------------------------------------------
module cpsc_error_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  cpsc_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpsc_pkg::SPEED_W-1:0] target_speed,
  input  logic signed [cpsc_pkg::SPEED_W-1:0] measured_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cpsc_pkg::terms_t                    out_terms
);

  localparam int DIFF_W  = cpsc_pkg::DIFF_W;
  localparam int ERR_W   = cpsc_pkg::ERR_W;
  localparam int INTEG_W = cpsc_pkg::INTEG_W;

  logic                      in_held;
  logic signed [cpsc_pkg::SPEED_W-1:0] target_q;
  logic signed [cpsc_pkg::SPEED_W-1:0] measured_q;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] integral_sum;

  logic                      stage_ready;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  err_lim;
  logic signed [DIFF_W-1:0]  diff_clamped;
  logic signed [ERR_W-1:0]   err_raw;
  logic [ERR_W-1:0]          err_mag;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W:0]   integ_lim;
  logic signed [INTEG_W:0]   integ_clamped;
  logic signed [cpsc_pkg::DERIV_W-1:0] deriv;

  // Ready chain
  assign stage_ready = !out_valid || out_ready;
  assign in_ready    = !in_held || stage_ready;

  // Clamp the error
  always_comb begin
    diff    = {target_q[cpsc_pkg::SPEED_W-1], target_q}
            - {measured_q[cpsc_pkg::SPEED_W-1], measured_q};
    err_lim = $signed({2'b00, cfg.error_limit});
    if (diff > err_lim) begin
      diff_clamped = err_lim;
    end else if (diff < -err_lim) begin
      diff_clamped = -err_lim;
    end else begin
      diff_clamped = diff;
    end
    err_raw = diff_clamped[ERR_W-1:0];
  end

  // Zero errors inside the deadband
  always_comb begin
    err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    err     = (err_mag < {1'b0, cfg.deadband}) ? '0 : err_raw;
  end

  // Accumulate and clamp the integral, form the derivative
  always_comb begin
    integ_sum = {integral_sum[INTEG_W-1], integral_sum}
              + {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err};
    integ_lim = $signed({2'b00, cfg.integral_limit});
    if (integ_sum > integ_lim) begin
      integ_clamped = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamped = -integ_lim;
    end else begin
      integ_clamped = integ_sum;
    end
    deriv = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held        <= 1'b0;
      out_valid      <= 1'b0;
      previous_error <= '0;
      integral_sum   <= '0;
    end else begin
      if (in_ready) begin
        in_held <= in_valid;
      end
      if (stage_ready) begin
        out_valid <= in_held;
      end
      if (stage_ready && in_held) begin
        previous_error <= err;
        integral_sum   <= integ_clamped[INTEG_W-1:0];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      target_q   <= target_speed;
      measured_q <= measured_speed;
    end
    if (stage_ready && in_held) begin
      out_terms.err   <= err;
      out_terms.integ <= integ_clamped[INTEG_W-1:0];
      out_terms.deriv <= deriv;
    end
  end

endmodule

### sv/cpsc_mult_stage.sv
// ----------------------------------------------------------------------------
// cpsc_mult_stage
// Weights error, integral and derivative by their gains.
// ----------------------------------------------------------------------------
module cpsc_mult_stage (
  input  logic             clk,
  input  logic             rst,
  input  cpsc_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  cpsc_pkg::terms_t in_terms,
  output logic             out_valid,
  input  logic             out_ready,
  output cpsc_pkg::prod_t  out_prod
);

  logic signed [cpsc_pkg::PP_W-1:0] pp;
  logic signed [cpsc_pkg::PI_W-1:0] pi;
  logic signed [cpsc_pkg::PD_W-1:0] pd;

  assign in_ready = !out_valid || out_ready;

  // Three parallel signed products
  assign pp = $signed(cfg.gain_p) * $signed(in_terms.err);
  assign pi = $signed(cfg.gain_i) * $signed(in_terms.integ);
  assign pd = $signed(cfg.gain_d) * $signed(in_terms.deriv);

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold products
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prod.pp <= pp;
      out_prod.pi <= pi;
      out_prod.pd <= pd;
    end
  end

endmodule

### sv/cpsc_drive_stage.sv
// ----------------------------------------------------------------------------
// cpsc_drive_stage
// Sums the weighted terms, drops fraction bits toward zero and saturates
// into the output register.
// ----------------------------------------------------------------------------
module cpsc_drive_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  cpsc_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cpsc_pkg::prod_t                     in_prod,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cpsc_pkg::DRIVE_W-1:0] drive
);

  localparam int SUM_W = cpsc_pkg::SUM_W;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] drv_lim;
  logic signed [SUM_W-1:0] drv_clamped;

  assign in_ready = !out_valid || out_ready;

  // Sum, truncate toward zero, saturate
  always_comb begin
    sum     = SUM_W'($signed(in_prod.pp)) + SUM_W'($signed(in_prod.pi))
            + SUM_W'($signed(in_prod.pd));
    biased  = sum + (sum[SUM_W-1] ? $signed(cpsc_pkg::ROUND_BIAS) : $signed(SUM_W'(0)));
    scaled  = biased >>> cpsc_pkg::FRAC_BITS;
    drv_lim = $signed({{(SUM_W - cpsc_pkg::LIM15_W){1'b0}}, cfg.drive_limit});
    if (scaled > drv_lim) begin
      drv_clamped = drv_lim;
    end else if (scaled < -drv_lim) begin
      drv_clamped = -drv_lim;
    end else begin
      drv_clamped = scaled;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      drive <= drv_clamped[cpsc_pkg::DRIVE_W-1:0];
    end
  end

endmodule

### sv/clamped_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// clamped_pid_speed_controller
// Positional PID speed loop with clamped error, clamped integral and
// saturated drive.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per control period on the s_t* channel: target speed and
//   measured speed. Each item yields exactly one drive item on m_t*.
//   The user writes gains and limits on the cfg_* channel (index, data)
//   only while no item is in flight; the block does not enforce this.
//   cfg_ready is always high. An item taken loads the input register, then
//   passes the error/integral register, the product register and the
//   output register before its drive shows on m_tvalid.
//   Throughput is one item per cycle while m_tready stays high; every stage
//   has its own valid flag, so bubbles close up and a new item is taken
//   while an earlier drive waits on the output.
//   Controller state (previous error, integral) updates as each item leaves
//   the error stage.
//   Reset clears all valid flags and the state and loads the register reset
//   values. When m_tready is low, the pipeline holds its items and s_tready
//   drops once every stage is full.
// ----------------------------------------------------------------------------
module clamped_pid_speed_controller (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: target_speed [15:0], measured_speed [31:16]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,
  // tdata: drive [15:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cpsc_pkg::cfg_t   cfg;
  cpsc_pkg::terms_t terms;
  cpsc_pkg::prod_t  prod;
  logic             terms_valid;
  logic             terms_ready;
  logic             prod_valid;
  logic             prod_ready;
  logic signed [cpsc_pkg::DRIVE_W-1:0] drive;

  cpsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpsc_error_stage u_err (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .target_speed   (s_tdata[15:0]),
    .measured_speed (s_tdata[31:16]),
    .out_valid      (terms_valid),
    .out_ready      (terms_ready),
    .out_terms      (terms)
  );

  cpsc_mult_stage u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_terms  (terms),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  cpsc_drive_stage u_drive (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .drive     (drive)
  );

  assign m_tdata = drive;

endmodule

### dv/clamped_pid_speed_controller_test.sv
// ----------------------------------------------------------------------------
// clamped_pid_speed_controller_test
// Self-checking testbench: drives speed items and register writes, predicts
// each drive item from a local copy of the controller state, and compares it
// with what the block delivers under random gaps, stalls and back-pressure.
// ----------------------------------------------------------------------------
module clamped_pid_speed_controller_test;
  import cpsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT       = 2_000_000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // tdata: target_speed [15:0], measured_speed [31:16]
  logic [31:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // tdata: drive [15:0]
  logic [15:0]           m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Controller model state and registers
  cfg_t                      pid_cfg;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [INTEG_W-1:0] integ_sum;

  logic [DRIVE_W-1:0] drive_q[$];
  int                 mismatches;
  bit                 send_idle;
  bit                 recv_idle;
  int                 hold_cycles;

  clamped_pid_speed_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the controller state by one item and return its drive
  function automatic logic [DRIVE_W-1:0] predict_drive(input logic signed [SPEED_W-1:0] tgt,
                                                       input logic signed [SPEED_W-1:0] meas);
    longint err;
    longint integ;
    longint deriv;
    longint sum;
    longint drv;
    err = clamp_sym(longint'(tgt) - longint'(meas), longint'(pid_cfg.error_limit));
    if ((err < 0 ? -err : err) < longint'(pid_cfg.deadband)) err = 0;
    integ = clamp_sym(longint'(integ_sum) + err, longint'(pid_cfg.integral_limit));
    deriv = err - longint'(prev_err);
    prev_err  = ERR_W'(err);
    integ_sum = INTEG_W'(integ);
    sum = longint'($signed(pid_cfg.gain_p)) * err
        + longint'($signed(pid_cfg.gain_i)) * integ
        + longint'($signed(pid_cfg.gain_d)) * deriv;
    // Integer division truncates toward zero, as the block must
    drv = sum / (longint'(1) << FRAC_BITS);
    return DRIVE_W'(clamp_sym(drv, longint'(pid_cfg.drive_limit)));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_P:         pid_cfg.gain_p = data[GAIN_W-1:0];
      REG_GAIN_I:         pid_cfg.gain_i = data[GAIN_W-1:0];
      REG_GAIN_D:         pid_cfg.gain_d = data[GAIN_W-1:0];
      REG_ERROR_LIMIT:    pid_cfg.error_limit = data[LIM15_W-1:0];
      REG_DEADBAND:       pid_cfg.deadband = data[LIM15_W-1:0];
      REG_INTEGRAL_LIMIT: pid_cfg.integral_limit = data[ILIM_W-1:0];
      REG_DRIVE_LIMIT:    pid_cfg.drive_limit = data[LIM15_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all_regs(input int gp, input int gi, input int gd, input int el,
                              input int db, input int il, input int dl);
    write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
    write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    write_reg(REG_ERROR_LIMIT, CFG_DATA_W'(el));
    write_reg(REG_DEADBAND, CFG_DATA_W'(db));
    write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(il));
    write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(dl));
  endtask

  // Offer one speed item after a random gap and record its drive once taken
  task automatic send_speed(input int tgt, input int meas);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {SPEED_W'(meas), SPEED_W'(tgt)};
    do @(posedge clk); while (!s_tready);
    drive_q.push_back(predict_drive(SPEED_W'(tgt), SPEED_W'(meas)));
  endtask

  // Drop valid and wait until every drive item is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int random_speed_delta();
    return $urandom_range(0, 400) - 200;
  endfunction

  task automatic send_random_speed();
    int meas;
    meas = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 4))
      0:       send_speed($urandom_range(0, 65535) - 32768, meas);
      1:       send_speed($urandom_range(0, 1) ? 32767 : -32768, meas);
      default: send_speed(meas + random_speed_delta(), meas);
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0:       return CFG_DATA_W'(16'h8000);
      1:       return CFG_DATA_W'(16'h7fff);
      2:       return CFG_DATA_W'($urandom);
      3:       return '0;
      default: return CFG_DATA_W'($urandom_range(0, 1200) - 600);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit(input int width, input int typical);
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return CFG_DATA_W'((1 << width) - 1);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, typical));
    endcase
  endfunction

  // Directed: reset values with extreme and ordinary speeds
  task automatic test_reset_values();
    send_speed(32767, -32768);
    send_speed(-32768, 32767);
    send_speed(0, 0);
    send_speed(100, 0);
    send_speed(-1, 0);
    settle();
  endtask

  // Directed: extreme gains, full limits, both edges of the deadband
  task automatic test_gains_and_deadband();
    set_all_regs(-32768, 32767, -1, 32767, 100, 8388607, 32767);
    send_speed(99, 0);
    send_speed(100, 0);
    send_speed(0, 99);
    send_speed(0, 100);
    send_speed(32767, -32768);
    send_speed(-32768, 32767);
    settle();
  endtask

  // Directed: negative sums truncate toward zero
  task automatic test_truncation();
    set_all_regs(1, 0, 0, 32767, 0, 8388607, 32767);
    send_speed(-1, 0);
    send_speed(-300, 0);
    send_speed(257, 0);
    settle();
  endtask

  // Directed: zero limits, then a deadband above the error limit
  task automatic test_zero_limits();
    set_all_regs(32767, 32767, 32767, 0, 0, 0, 0);
    send_speed(32767, -32768);
    send_speed(-32768, 32767);
    settle();
    set_all_regs(256, 256, 256, 100, 200, 5000, 32767);
    send_speed(5000, 0);
    send_speed(-5000, 0);
    settle();
  endtask

  // Directed: lower the integral limit below the accumulated sum
  task automatic test_integral_lowered();
    set_all_regs(0, 256, 0, 32767, 0, 8388607, 32767);
    send_speed(30000, 0);
    send_speed(30000, 0);
    send_speed(30000, 0);
    settle();
    write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(1000));
    send_speed(-5, 0);
    settle();
  endtask

  // Directed: a write to an index outside the map changes nothing
  task automatic test_unused_index();
    write_reg(REG_UNUSED, '1);
    send_speed(1234, -77);
    settle();
  endtask

  // Hold the output off while the sender keeps pushing
  task automatic test_backpressure();
    send_idle   = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (40) send_random_speed();
    settle();
  endtask

  // Random phases: fresh registers, then a run of random speed items
  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      send_idle = (p % 3) != 0;
      recv_idle = (p % 4) != 1;
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      write_reg(REG_ERROR_LIMIT, pick_limit(LIM15_W, 8000));
      write_reg(REG_DEADBAND, pick_limit(LIM15_W, 60));
      write_reg(REG_INTEGRAL_LIMIT, pick_limit(ILIM_W, 200000));
      write_reg(REG_DRIVE_LIMIT, pick_limit(LIM15_W, 20000));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      repeat (PHASE_ITEMS) send_random_speed();
      settle();
    end
  endtask

  // Output side: random stall per item, plus a long hold when requested
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = recv_idle ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  // Compare each drive item with the oldest prediction
  always @(posedge clk) begin
    logic [DRIVE_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: drive item %0d with no prediction pending",
                   $signed(m_tdata));
      end else begin
        want = drive_q.pop_front();
        if (m_tdata !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: drive expected %0d, got %0d", $signed(want), $signed(m_tdata));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    mismatches  = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    hold_cycles = 0;
    pid_cfg.gain_p         = RST_GAIN_P;
    pid_cfg.gain_i         = RST_GAIN_I;
    pid_cfg.gain_d         = RST_GAIN_D;
    pid_cfg.error_limit    = RST_ERROR_LIMIT;
    pid_cfg.deadband       = RST_DEADBAND;
    pid_cfg.integral_limit = RST_INTEGRAL_LIMIT;
    pid_cfg.drive_limit    = RST_DRIVE_LIMIT;
    prev_err  = '0;
    integ_sum = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_gains_and_deadband();
    test_truncation();
    test_zero_limits();
    test_integral_lowered();
    test_unused_index();
    test_backpressure();
    test_random_phases();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
